// ===== sv/agent_goal_distance_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// agent goal distance tracker assertion macros
// shared property forms clocked on aclk and gated by reset
// ----------------------------------------------------------------------------
`ifndef AGENT_GOAL_DISTANCE_TRACKER_ASSERT_SVH
`define AGENT_GOAL_DISTANCE_TRACKER_ASSERT_SVH

// same-cycle implication
`define AGDT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define AGDT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/agdt_pkg.sv =====
// ----------------------------------------------------------------------------
// agdt_pkg
// shared constants, command codes and types of the goal distance tracker
// ----------------------------------------------------------------------------
package agdt_pkg;

    localparam int AGENT_COUNT = 256;
    localparam int AGENT_W     = $clog2(AGENT_COUNT);
    localparam int VEC_LEN     = 8;
    localparam int ELEM_W      = 16;
    localparam int GOAL_W      = VEC_LEN * ELEM_W;
    localparam int SQ_W        = 33;
    localparam int SUM_W       = 36;
    localparam int ROOT_IN_W   = 35;
    localparam int ROOT_W      = 18;
    localparam int DIST_W      = 17;
    localparam int CNT_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [CNT_W-1:0]  CNT_MAX = 16'hFFFF;

    localparam logic [2:0] CMD_SET_GOAL = 3'd0;
    localparam logic [2:0] CMD_CHECK    = 3'd1;
    localparam logic [2:0] CMD_SIM      = 3'd2;
    localparam logic [2:0] CMD_ERROR    = 3'd3;
    localparam logic [2:0] CMD_INHERIT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

// ===== sv/agent_goal_distance_tracker.sv =====
// ----------------------------------------------------------------------------
// agent_goal_distance_tracker
// per-agent goal records, normalized distance, similarity and stall tracking
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  s_      | cmd, agent, source, elem_0..7   | in
//  m_      | distance, similarity, status    | out
//  cfg_    | index, data                     | in
//
//  distance commands on an agent with a goal pass eight lane squares, one
//  merge add, then 18 steps of the shared square root unit that set the figure
//  other commands skip these and finish after the registered ram read
//  reset clears flags and counter valid bits at once, no clearing pass
//  a waiting result holds the sequencer in its last state until taken
// ----------------------------------------------------------------------------
module agent_goal_distance_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_cmd,
    input  logic [7:0]                          s_agent,
    input  logic [7:0]                          s_source_agent,
    input  logic signed [15:0]                  s_elem_0,
    input  logic signed [15:0]                  s_elem_1,
    input  logic signed [15:0]                  s_elem_2,
    input  logic signed [15:0]                  s_elem_3,
    input  logic signed [15:0]                  s_elem_4,
    input  logic signed [15:0]                  s_elem_5,
    input  logic signed [15:0]                  s_elem_6,
    input  logic signed [15:0]                  s_elem_7,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [16:0]                         m_distance,
    output logic [16:0]                         m_similarity,
    output logic                                m_goal_present,
    output logic [15:0]                         m_stall_count,
    output logic                                m_stalled,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [agdt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [16:0]                         cfg_data
);
    import agdt_pkg::*;
    `include "agent_goal_distance_tracker_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [15:0]       limit_reg;
    logic [DIST_W-1:0] thresh_reg;

    logic [2:0]              cmd_reg;
    logic [AGENT_W-1:0]      agent_reg, src_reg;
    logic [ELEM_W-1:0]       elem_reg [VEC_LEN];
    logic [ELEM_W-1:0]       elem_in [VEC_LEN];
    logic [SQ_W-1:0]         sq [VEC_LEN];
    logic [SUM_W-1:0]        sum_reg, sum_tree;
    logic [DIST_W-1:0]       dist_reg;

    logic [AGENT_COUNT-1:0]  flag_reg, cvld_reg;

    logic [GOAL_W-1:0] goal_q;
    logic [CNT_W-1:0]  cnt_q, cnt_cur, cnt_new;
    logic              goal_we, cnt_we, flag_new;
    logic [GOAL_W-1:0] goal_wdata;

    logic              accept, fire, need_dist, flag_cur, is_dist;
    root_stat_t        rstat;
    logic [ROOT_W-1:0] root;

    assign elem_in[0] = s_elem_0;
    assign elem_in[1] = s_elem_1;
    assign elem_in[2] = s_elem_2;
    assign elem_in[3] = s_elem_3;
    assign elem_in[4] = s_elem_4;
    assign elem_in[5] = s_elem_5;
    assign elem_in[6] = s_elem_6;
    assign elem_in[7] = s_elem_7;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign fire      = (state_reg == S_DONE) && (!m_valid || m_ready);

    assign flag_cur  = flag_reg[agent_reg];
    assign is_dist   = (cmd_reg == CMD_CHECK) || (cmd_reg == CMD_SIM) ||
                       (cmd_reg == CMD_ERROR);
    assign need_dist = flag_cur && is_dist;
    assign cnt_cur   = cvld_reg[agent_reg] ? cnt_q : '0;

    // goal ram, read at the source for inherit
    agdt_ram #(.WIDTH(GOAL_W), .DEPTH(AGENT_COUNT)) u_goal_ram (
        .aclk  (aclk),
        .we    (goal_we),
        .waddr (agent_reg),
        .wdata (goal_wdata),
        .re    (accept),
        .raddr ((s_cmd == CMD_INHERIT) ? s_source_agent[AGENT_W-1:0]
                                       : s_agent[AGENT_W-1:0]),
        .q     (goal_q)
    );

    agdt_ram #(.WIDTH(CNT_W), .DEPTH(AGENT_COUNT)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (agent_reg),
        .wdata (cnt_new),
        .re    (accept),
        .raddr (s_agent[AGENT_W-1:0]),
        .q     (cnt_q)
    );

    for (genvar g = 0; g < VEC_LEN; g++) begin : g_lane
        agdt_lane u_lane (
            .aclk   (aclk),
            .en     (state_reg == S_READ),
            .elem   (elem_reg[g]),
            .goal   (goal_q[g*ELEM_W +: ELEM_W]),
            .sq_reg (sq[g])
        );
    end

    // merge of the lane squares
    always_comb begin
        sum_tree = '0;
        for (int i = 0; i < VEC_LEN; i++) begin
            sum_tree = sum_tree + {{(SUM_W-SQ_W){1'b0}}, sq[i]};
        end
    end

    agdt_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_SUM),
        .x_in    (sum_reg[SUM_W-1:1]),
        .stat    (rstat),
        .root    (root)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ: state_next = need_dist ? S_SQ : S_DONE;
            S_SQ:   state_next = S_SUM;
            S_SUM:  state_next = S_ROOT;
            S_ROOT: if (rstat.done) state_next = S_DONE;
            S_DONE: if (fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // record update at completion
    always_comb begin
        goal_we    = 1'b0;
        goal_wdata = goal_q;
        cnt_we     = 1'b0;
        cnt_new    = cnt_cur;
        flag_new   = flag_cur;
        priority if (cmd_reg == CMD_SET_GOAL) begin
            goal_we = fire;
            for (int i = 0; i < VEC_LEN; i++) begin
                goal_wdata[i*ELEM_W +: ELEM_W] = elem_reg[i];
            end
            flag_new = 1'b1;
            cnt_we   = fire;
            cnt_new  = '0;
        end else if (cmd_reg == CMD_INHERIT) begin
            goal_we  = fire && (src_reg != agent_reg);
            flag_new = flag_reg[src_reg];
            cnt_we   = fire;
            cnt_new  = '0;
        end else if (cmd_reg == CMD_CHECK && flag_cur) begin
            cnt_we = fire;
            if (dist_reg > thresh_reg) begin
                cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 16'd1;
            end else begin
                cnt_new = (cnt_cur >= 16'd2) ? cnt_cur - 16'd2 : '0;
            end
        end else begin
            cnt_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            m_valid    <= 1'b0;
            flag_reg   <= '0;
            cvld_reg   <= '0;
            limit_reg  <= 16'd20;
            thresh_reg <= 17'd3277;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_STALL_LIMIT) limit_reg <= cfg_data[15:0];
                if (cfg_index == CFG_NEAR_THRESH) thresh_reg <= cfg_data;
            end
            if (fire) begin
                m_valid             <= 1'b1;
                flag_reg[agent_reg] <= flag_new;
                if (cnt_we) cvld_reg[agent_reg] <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_cmd;
            agent_reg <= s_agent[AGENT_W-1:0];
            src_reg   <= s_source_agent[AGENT_W-1:0];
            for (int i = 0; i < VEC_LEN; i++) begin
                elem_reg[i] <= elem_in[i];
            end
        end
        if (state_reg == S_READ) dist_reg <= '0;
        if (state_reg == S_SQ) sum_reg <= sum_tree;
        if (state_reg == S_ROOT && rstat.done) begin
            dist_reg <= ({1'b0, root} > {1'b0, ONE_Q16}) ? ONE_Q16
                                                         : root[DIST_W-1:0];
        end
        if (fire) begin
            m_distance     <= dist_reg;
            m_similarity   <= (cmd_reg == CMD_SIM && flag_cur) ? ONE_Q16 - dist_reg : '0;
            m_goal_present <= flag_new;
            m_stall_count  <= cnt_new;
            m_stalled      <= (cnt_new >= limit_reg);
        end
    end

    `AGDT_ASSERT_NEXT(a_accept_busy, accept, !s_ready)
    `AGDT_ASSERT_NOW(a_dist_range, m_valid, m_distance <= ONE_Q16)
    `AGDT_ASSERT_NOW(a_sim_sum, m_valid && m_similarity != '0,
                     m_distance + m_similarity == ONE_Q16)
    `AGDT_ASSERT_NOW(a_root_idle, state_reg == S_IDLE, !rstat.busy)
endmodule

// ===== sv/agdt_ram.sv =====
// ----------------------------------------------------------------------------
// agdt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module agdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            q <= mem[raddr];
        end
    end
endmodule

// ===== sv/agdt_lane.sv =====
// ----------------------------------------------------------------------------
// agdt_lane
// one element lane: difference to goal and registered square
// ----------------------------------------------------------------------------
module agdt_lane (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [agdt_pkg::ELEM_W-1:0] elem,
    input  logic signed [agdt_pkg::ELEM_W-1:0] goal,
    output logic [agdt_pkg::SQ_W-1:0]          sq_reg
);
    import agdt_pkg::*;

    logic signed [ELEM_W:0]     diff;
    logic signed [2*ELEM_W+1:0] prod;

    assign diff = {elem[ELEM_W-1], elem} - {goal[ELEM_W-1], goal};
    assign prod = diff * diff;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= prod[SQ_W-1:0];
        end
    end
endmodule

// ===== sv/agdt_isqrt.sv =====
// ----------------------------------------------------------------------------
// agdt_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module agdt_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [agdt_pkg::ROOT_IN_W-1:0] x_in,
    output agdt_pkg::root_stat_t         stat,
    output logic [agdt_pkg::ROOT_W-1:0]  root
);
    import agdt_pkg::*;

    localparam logic [ROOT_IN_W-1:0] BIT_TOP = {1'b1, {(ROOT_IN_W-1){1'b0}}};

    logic [ROOT_IN_W-1:0] x_reg, x_next;
    logic [ROOT_IN_W-1:0] r_reg, r_next;
    logic [ROOT_IN_W-1:0] bit_reg, bit_next;
    logic                 done_reg, done_next;
    logic [ROOT_IN_W:0]   trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start) begin
            x_next   = x_in;
            r_next   = '0;
            bit_next = BIT_TOP;
        end else if (bit_reg != '0) begin
            if ({1'b0, x_reg} >= trial) begin
                x_next = x_reg - trial[ROOT_IN_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = (bit_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        r_reg <= r_next;
    end

    assign stat.busy = (bit_reg != '0);
    assign stat.done = done_reg;
    assign root      = r_reg[ROOT_W-1:0];
endmodule

// ===== tb/agent_goal_distance_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// agent goal distance tracker testbench
// drives commands with random idling on both channels, predicts each result
// from a local copy of the agent records and compares it with the whole result beat
// ----------------------------------------------------------------------------
module agent_goal_distance_tracker_tb;
    import agdt_pkg::*;

    localparam logic [2:0] CMD_STALLED = 3'd5;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [16:0] distance;
        logic [16:0] similarity;
        logic        goal_present;
        logic [15:0] counter;
        logic        stalled;
    } status_t;

    typedef struct {
        logic [2:0]         cmd;
        logic [7:0]         agent;
        logic [7:0]         source_agent;
        logic signed [15:0] elem [VEC_LEN];
    } request_t;

    class tracker_scoreboard;
        logic signed [15:0] goals [AGENT_COUNT][VEC_LEN];
        bit                 goal_set [AGENT_COUNT];
        logic [15:0]        counts [AGENT_COUNT];
        logic [15:0]        stall_limit;
        logic [16:0]        near_threshold;
        status_t            pending [$];
        int                 mismatches;
        int                 checked;

        function void clear();
            for (int a = 0; a < AGENT_COUNT; a++) begin
                goal_set[a] = 1'b0;
                counts[a] = '0;
                for (int i = 0; i < VEC_LEN; i++) goals[a][i] = '0;
            end
            stall_limit = 16'd20;
            near_threshold = 17'd3277;
            mismatches = 0;
            checked = 0;
        endfunction

        function logic [16:0] goal_distance(int a, request_t r);
            longint unsigned sum;
            longint unsigned x;
            longint unsigned root;
            longint unsigned bit_v;
            longint diff;
            sum = 0;
            for (int i = 0; i < VEC_LEN; i++) begin
                diff = longint'(r.elem[i]) - longint'(goals[a][i]);
                sum += longint'(diff * diff);
            end
            x = sum >> 1;
            root = 0;
            bit_v = 64'd1 << 36;
            while (bit_v > x) bit_v >>= 2;
            while (bit_v != 0) begin
                if (x >= root + bit_v) begin
                    x -= root + bit_v;
                    root = (root >> 1) + bit_v;
                end else begin
                    root >>= 1;
                end
                bit_v >>= 2;
            end
            if (root > 65536) root = 65536;
            return root[16:0];
        endfunction

        function void note_request(request_t r);
            status_t s;
            int a;
            int src;
            a = r.agent;
            src = r.source_agent;
            s = '0;
            case (r.cmd)
                CMD_SET_GOAL: begin
                    for (int i = 0; i < VEC_LEN; i++) goals[a][i] = r.elem[i];
                    goal_set[a] = 1'b1;
                    counts[a] = '0;
                end
                CMD_CHECK: if (goal_set[a]) begin
                    s.distance = goal_distance(a, r);
                    if (s.distance > near_threshold) begin
                        if (counts[a] != CNT_MAX) counts[a]++;
                    end else begin
                        counts[a] = (counts[a] >= 16'd2) ? counts[a] - 16'd2 : 16'd0;
                    end
                end
                CMD_SIM: if (goal_set[a]) begin
                    s.distance = goal_distance(a, r);
                    s.similarity = ONE_Q16 - s.distance;
                end
                CMD_ERROR: if (goal_set[a]) s.distance = goal_distance(a, r);
                CMD_INHERIT: begin
                    if (src != a) begin
                        goals[a] = goals[src];
                        goal_set[a] = goal_set[src];
                    end
                    counts[a] = '0;
                end
                default: ;
            endcase
            s.goal_present = goal_set[a];
            s.counter = counts[a];
            s.stalled = counts[a] >= stall_limit;
            pending.push_back(s);
        endfunction

        function void check_result(status_t got);
            status_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_cmd;
    logic [7:0] s_agent;
    logic [7:0] s_source_agent;
    logic signed [15:0] s_elem [VEC_LEN];
    logic m_valid;
    logic m_ready;
    logic [16:0] m_distance;
    logic [16:0] m_similarity;
    logic m_goal_present;
    logic [15:0] m_stall_count;
    logic m_stalled;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [16:0] cfg_data;

    tracker_scoreboard board;
    bit with_idling;
    bit with_gaps;
    int idle_cycles;
    int sent;
    bit timed_out;

    agent_goal_distance_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_agent(s_agent),
        .s_source_agent(s_source_agent),
        .s_elem_0(s_elem[0]), .s_elem_1(s_elem[1]), .s_elem_2(s_elem[2]),
        .s_elem_3(s_elem[3]), .s_elem_4(s_elem[4]), .s_elem_5(s_elem[5]),
        .s_elem_6(s_elem[6]), .s_elem_7(s_elem[7]),
        .m_valid(m_valid), .m_ready(m_ready), .m_distance(m_distance),
        .m_similarity(m_similarity), .m_goal_present(m_goal_present),
        .m_stall_count(m_stall_count), .m_stalled(m_stalled),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stall, sample at rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_distance, m_similarity, m_goal_present,
                                m_stall_count, m_stalled});
        end
    end

    always @(negedge aclk) begin
        m_ready <= with_gaps ? ($urandom_range(99) >= 32) : 1'b1;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [16:0] value);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_STALL_LIMIT) board.stall_limit = value[15:0];
        else if (idx == CFG_NEAR_THRESH) board.near_threshold = value;
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_request(request_t r);
        @(negedge aclk);
        while (with_idling && $urandom_range(99) < 32) @(negedge aclk);
        s_valid <= 1;
        s_cmd <= r.cmd;
        s_agent <= r.agent;
        s_source_agent <= r.source_agent;
        for (int i = 0; i < VEC_LEN; i++) s_elem[i] <= r.elem[i];
        do @(posedge aclk); while (!s_ready);
        board.note_request(r);
        sent++;
        @(negedge aclk);
        s_valid <= 0;
    endtask

    function automatic request_t make_request(logic [2:0] cmd, logic [7:0] agent,
                                              logic [7:0] source_agent, int fill);
        request_t r;
        r.cmd = cmd;
        r.agent = agent;
        r.source_agent = source_agent;
        for (int i = 0; i < VEC_LEN; i++) r.elem[i] = 16'(fill);
        return r;
    endfunction

    // random item; most elements lie near the agent's goal in the local copy, the rest are random or extremes
    function automatic request_t random_request(int hot);
        request_t r;
        int pick;
        pick = $urandom_range(99);
        r.agent = (pick < 85) ? 8'($urandom_range(hot)) : 8'($urandom);
        r.source_agent = ($urandom_range(3) == 0) ? r.agent : 8'($urandom_range(hot));
        pick = $urandom_range(99);
        if (pick < 10) r.cmd = CMD_SET_GOAL;
        else if (pick < 55) r.cmd = CMD_CHECK;
        else if (pick < 68) r.cmd = CMD_SIM;
        else if (pick < 78) r.cmd = CMD_ERROR;
        else if (pick < 86) r.cmd = CMD_INHERIT;
        else if (pick < 95) r.cmd = CMD_STALLED;
        else r.cmd = 3'($urandom_range(7, 6));
        for (int i = 0; i < VEC_LEN; i++) begin
            case ($urandom_range(5))
                0: r.elem[i] = 16'($urandom);
                1: r.elem[i] = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
                default: r.elem[i] = 16'(board.goals[r.agent][i] + $signed($urandom_range(1200)) - 600);
            endcase
        end
        return r;
    endfunction

    task automatic random_phase(int count, int hot);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            send_request(random_request(hot));
        end
    endtask

    initial begin
        board = new();
        board.clear();
        sent = 0;
        with_idling = 0;
        with_gaps = 0;
        aresetn = 0;
        s_valid = 0;
        s_cmd = '0;
        s_agent = '0;
        s_source_agent = '0;
        for (int i = 0; i < VEC_LEN; i++) s_elem[i] = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: no-goal reads, extremes, all commands
        send_request(make_request(CMD_CHECK, 8'd3, 8'd0, 0));
        send_request(make_request(CMD_SIM, 8'd255, 8'd0, 0));
        send_request(make_request(3'd6, 8'd3, 8'd0, 0));
        send_request(make_request(CMD_SET_GOAL, 8'd0, 8'd0, -32768));
        send_request(make_request(CMD_CHECK, 8'd0, 8'd0, 32767));
        send_request(make_request(CMD_SIM, 8'd0, 8'd0, 32767));
        send_request(make_request(CMD_ERROR, 8'd0, 8'd0, -32768));
        send_request(make_request(CMD_SIM, 8'd0, 8'd0, -32768));
        send_request(make_request(CMD_SET_GOAL, 8'd255, 8'd0, 32767));
        send_request(make_request(CMD_ERROR, 8'd255, 8'd0, 30000));
        send_request(make_request(CMD_CHECK, 8'd255, 8'd0, 32767));
        send_request(make_request(CMD_INHERIT, 8'd7, 8'd255, 0));
        send_request(make_request(CMD_INHERIT, 8'd7, 8'd7, 0));
        send_request(make_request(CMD_INHERIT, 8'd8, 8'd9, 0));
        send_request(make_request(CMD_STALLED, 8'd7, 8'd0, 0));
        send_request(make_request(3'd7, 8'd255, 8'd0, -1));
        for (int k = 0; k < 3; k++) send_request(make_request(CMD_CHECK, 8'd0, 8'd0, 32767));
        wait_drained();

        write_register(CFG_STALL_LIMIT, 17'd1);
        write_register(CFG_NEAR_THRESH, 17'd0);
        send_request(make_request(CMD_CHECK, 8'd255, 8'd0, 32766));
        send_request(make_request(CMD_STALLED, 8'd0, 8'd0, 0));
        send_request(make_request(CMD_CHECK, 8'd0, 8'd0, -32768));
        wait_drained();

        // random phases, no idling first
        random_phase(250, 15);
        wait_drained();
        with_idling = 1;
        with_gaps = 1;
        write_register(CFG_STALL_LIMIT, 17'd65535);
        write_register(CFG_NEAR_THRESH, 17'd65536);
        random_phase(300, 255);
        wait_drained();
        write_register(CFG_STALL_LIMIT, 17'd4);
        write_register(CFG_NEAR_THRESH, 17'd200);
        random_phase(450, 7);
        wait_drained();
        write_register(CFG_STALL_LIMIT, 17'($urandom_range(65535, 1)));
        write_register(CFG_NEAR_THRESH, 17'($urandom_range(65536)));
        random_phase(430, 31);

        wait_drained();
        $display("sent %0d request beats, checked %0d result beats over five register settings",
                 sent, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0 && !timed_out) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.pending.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
